/* design/dfir_pkg.sv */
// shared types and constants of the decimating fir filter
`timescale 1ns / 1ps

package dfir_pkg;

	localparam int TAP_COUNT_W  = 7;
	localparam int DECIMATION_W = 5;
	localparam int TAP_INDEX_W  = 6;
	localparam int CFG_INDEX_W  = 2;
	localparam int CFG_DATA_W   = 7;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_MAC    = 2'd1,
		ST_FINISH = 2'd2
	} state_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_TAP_COUNT    = 2'd0,
		CFG_DECIMATION   = 2'd1,
		CFG_COMPLEX_MODE = 2'd2
	} cfg_index_t;

	typedef enum logic {
		CMD_LOAD   = 1'b0,
		CMD_SAMPLE = 1'b1
	} command_t;

endpackage

/* design/decimating_fir_filter.sv */
// top level of the decimating fir filter: control, shared complex mac, rounding
`timescale 1ns / 1ps

// Decimating FIR filter, real or complex, Q1.15. A load beat writes one coefficient, and a
// sample beat that emits no result only writes the history. A sample beat that emits a
// result starts a walk over n taps, n being the smaller of the tap count and the samples
// seen so far in the vector (at most MAX_TAPS), or over none when the tap count is zero: one
// shared complex multiply-accumulate walks one tap a cycle through the coefficient and
// history memories, then the sum is rounded and saturated. The input side stalls while a
// sum is in progress; the next beat is taken while a finished result still waits in the
// output register, and a second result waits in the rounding stage until that register is
// free. Configuration writes are taken every cycle.
module decimating_fir_filter #(
	parameter int MAX_TAPS       = 64,
	parameter int MAX_DECIMATION = 16,
	parameter int SAMPLE_BITS    = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic                                    command,
	input  logic [dfir_pkg::TAP_INDEX_W-1:0]        tap_index,
	input  logic signed [SAMPLE_BITS-1:0]           value_re,
	input  logic signed [SAMPLE_BITS-1:0]           value_im,
	input  logic                                    start_vector,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic signed [SAMPLE_BITS-1:0]           result_re,
	output logic signed [SAMPLE_BITS-1:0]           result_im,
	output logic                                    saturated,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [dfir_pkg::CFG_INDEX_W-1:0]        cfg_index,
	input  logic [dfir_pkg::CFG_DATA_W-1:0]         cfg_data
);

	import dfir_pkg::*;

	localparam int SB        = SAMPLE_BITS;
	localparam int FRAC_BITS = SB - 1;
	localparam int ADDR_W    = MAX_TAPS > 1 ? $clog2(MAX_TAPS) : 1;
	localparam int TAP_W     = $clog2(MAX_TAPS + 1);
	localparam int PH_W      = MAX_DECIMATION > 1 ? $clog2(MAX_DECIMATION) : 1;
	localparam int DEC_W     = $clog2(MAX_DECIMATION + 1);
	localparam int ACC_W     = 2 * SB + TAP_W + 2;

	localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) << (FRAC_BITS - 1);
	localparam logic signed [ACC_W-1:0] TOP = ACC_W'(1) << (2 * SB - 2);
	localparam logic signed [ACC_W-1:0] BOT = -TOP;

	function automatic logic [SB:0] round_sat(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-1:0] b;
		logic [SB:0]             r;
		b = acc + RND;
		if (b >= TOP) begin
			r = {1'b1, 1'b0, {(SB - 1){1'b1}}};
		end else if (b < BOT) begin
			r = {1'b1, 1'b1, {(SB - 1){1'b0}}};
		end else begin
			r = {1'b0, b[FRAC_BITS +: SB]};
		end
		return r;
	endfunction

	// configuration registers
	logic [TAP_COUNT_W-1:0]  tap_count_q;
	logic [DECIMATION_W-1:0] decimation_q;
	logic                    complex_mode_q;

	// control state
	state_t              state_q, state_d;
	logic [ADDR_W-1:0]   rp_q;
	logic [TAP_W-1:0]    seen_q;
	logic [PH_W-1:0]     phase_q;
	logic [TAP_W-1:0]    n_q;
	logic [TAP_W-1:0]    issue_cnt_q;
	logic [ADDR_W-1:0]   ptr_q;
	logic                rd_s1;
	logic                mul_s2;
	logic                out_valid_q;

	// datapath
	logic signed [2*SB-1:0] p_rr_s2, p_ii_s2, p_ri_s2, p_ir_s2;
	logic signed [ACC_W-1:0] acc_re_q, acc_im_q;
	logic signed [SB-1:0]    result_re_q, result_im_q;
	logic                    saturated_q;

	logic                    accept, is_load, coef_we, hist_we, emit, start_mac;
	logic                    mac_issue, out_load;
	logic [TAP_W-1:0]        taps_eff, seen_cur, seen_new, n_new;
	logic [DEC_W-1:0]        dec_eff, phase_inc;
	logic [PH_W-1:0]         phase_cur, phase_new;
	logic [ADDR_W-1:0]       rp_inc, ptr_dec;
	logic [2*SB-1:0]         coef_rd, hist_rd;
	logic signed [SB-1:0]    br, bi, xr, xi;
	logic [SB:0]             rnd_re, rnd_im;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid & ~in_stall;
	assign is_load   = (command == CMD_LOAD);
	assign coef_we   = accept & is_load & (int'(tap_index) < MAX_TAPS);
	assign hist_we   = accept & ~is_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q    <= TAP_COUNT_W'(1);
			decimation_q   <= DECIMATION_W'(1);
			complex_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_TAP_COUNT:    tap_count_q    <= cfg_data[TAP_COUNT_W-1:0];
				CFG_DECIMATION:   decimation_q   <= cfg_data[DECIMATION_W-1:0];
				CFG_COMPLEX_MODE: complex_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// clamped register values and vector bookkeeping
	always_comb begin
		taps_eff  = (int'(tap_count_q) > MAX_TAPS) ? TAP_W'(MAX_TAPS) : TAP_W'(tap_count_q);
		if (decimation_q == '0) begin
			dec_eff = DEC_W'(1);
		end else if (int'(decimation_q) > MAX_DECIMATION) begin
			dec_eff = DEC_W'(MAX_DECIMATION);
		end else begin
			dec_eff = DEC_W'(decimation_q);
		end
		seen_cur  = start_vector ? '0 : seen_q;
		phase_cur = start_vector ? '0 : phase_q;
		seen_new  = (int'(seen_cur) < MAX_TAPS) ? seen_cur + TAP_W'(1) : seen_cur;
		n_new     = (seen_new < taps_eff) ? seen_new : taps_eff;
		phase_inc = DEC_W'(phase_cur) + DEC_W'(1);
		phase_new = (phase_inc >= dec_eff) ? '0 : PH_W'(phase_inc);
		emit      = (phase_cur == '0);
		rp_inc    = (int'(rp_q) == MAX_TAPS - 1) ? '0 : rp_q + ADDR_W'(1);
		ptr_dec   = (ptr_q == '0) ? ADDR_W'(MAX_TAPS - 1) : ptr_q - ADDR_W'(1);
	end

	assign start_mac = hist_we & emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mac_issue = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start_mac) begin
					state_d = ST_MAC;
				end
			end
			ST_MAC: begin
				mac_issue = (issue_cnt_q < n_q);
				if (!mac_issue && !rd_s1 && !mul_s2) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q        <= '0;
			seen_q      <= '0;
			phase_q     <= '0;
			n_q         <= '0;
			issue_cnt_q <= '0;
			ptr_q       <= '0;
			rd_s1       <= 1'b0;
			mul_s2      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (hist_we) begin
				rp_q    <= rp_inc;
				seen_q  <= seen_new;
				phase_q <= phase_new;
			end
			if (start_mac) begin
				n_q         <= n_new;
				issue_cnt_q <= '0;
				ptr_q       <= rp_q;
			end else if (mac_issue) begin
				issue_cnt_q <= issue_cnt_q + TAP_W'(1);
				ptr_q       <= ptr_dec;
			end
			rd_s1  <= mac_issue;
			mul_s2 <= rd_s1;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	dfir_ram #(
		.WIDTH (2 * SB),
		.DEPTH (MAX_TAPS)
	) u_coef_ram (
		.clk     (clk),
		.wr_en   (coef_we),
		.wr_addr (ADDR_W'(tap_index)),
		.wr_data ({value_im, value_re}),
		.rd_en   (mac_issue),
		.rd_addr (issue_cnt_q[ADDR_W-1:0]),
		.rd_data (coef_rd)
	);

	dfir_ram #(
		.WIDTH (2 * SB),
		.DEPTH (MAX_TAPS)
	) u_hist_ram (
		.clk     (clk),
		.wr_en   (hist_we),
		.wr_addr (rp_q),
		.wr_data ({value_im, value_re}),
		.rd_en   (mac_issue),
		.rd_addr (ptr_q),
		.rd_data (hist_rd)
	);

	// imaginary parts drop out in real mode
	always_comb begin
		br = coef_rd[SB-1:0];
		xr = hist_rd[SB-1:0];
		bi = complex_mode_q ? coef_rd[2*SB-1:SB] : '0;
		xi = complex_mode_q ? hist_rd[2*SB-1:SB] : '0;
	end

	always_ff @(posedge clk) begin
		p_rr_s2 <= br * xr;
		p_ii_s2 <= bi * xi;
		p_ri_s2 <= br * xi;
		p_ir_s2 <= bi * xr;
		if (start_mac) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else if (mul_s2) begin
			acc_re_q <= acc_re_q + ACC_W'(p_rr_s2) - ACC_W'(p_ii_s2);
			acc_im_q <= acc_im_q + ACC_W'(p_ri_s2) + ACC_W'(p_ir_s2);
		end
	end

	assign rnd_re = round_sat(acc_re_q);
	assign rnd_im = round_sat(acc_im_q);

	always_ff @(posedge clk) begin
		if (out_load) begin
			result_re_q <= rnd_re[SB-1:0];
			result_im_q <= rnd_im[SB-1:0];
			saturated_q <= rnd_re[SB] | rnd_im[SB];
		end
	end

	assign out_valid = out_valid_q;
	assign result_re = result_re_q;
	assign result_im = result_im_q;
	assign saturated = saturated_q;

`ifndef SYNTHESIS
	a_issue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MAC) |-> (issue_cnt_q <= n_q))
		else $error("tap walk ran past its count");

	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(seen_q) <= MAX_TAPS)
		else $error("sample count beyond history depth");

	a_finish_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && out_valid_q && out_stall) |=> (state_q == ST_FINISH))
		else $error("result left rounding stage while output register was full");

	a_read_in_mac: assert property (@(posedge clk) disable iff (!arst_n)
		rd_s1 |-> ($past(state_q) == ST_MAC))
		else $error("memory read outside the tap walk");

	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_s1 || mul_s2) |-> in_stall)
		else $error("input beat taken while mac pipeline busy");
`endif

endmodule

/* design/dfir_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps

module dfir_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                 clk,
	input  logic                                 wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                     wr_data,
	input  logic                                 rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                     rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
